// File: hdl/aes128_pkg.sv
`timescale 1ns / 1ps
package aes128_pkg;

    localparam int NumRounds = 10;
    localparam int KeyIdxW = 1;
    localparam logic [KeyIdxW-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [KeyIdxW-1:0] REG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_beat_t;

    typedef logic [127:0] block_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] RCON [1:10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

    localparam logic [7:0] GF_REDUCE = 8'h1b;

    // byte n of a block sits at bits 127-8n
    function automatic logic [7:0] get_byte(block_t b, int n);
        return b[127 - 8*n -: 8];
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] v);
        return v[7] ? ({v[6:0], 1'b0} ^ GF_REDUCE) : {v[6:0], 1'b0};
    endfunction

    function automatic logic [31:0] sub_word(logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic block_t next_round_key(block_t k, logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic block_t sub_shift(block_t s);
        block_t r;
        r = '0;
        for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
                r[127 - 8*(c*4 + w) -: 8] = SBOX[get_byte(s, ((c + w) % 4)*4 + w)];
        return r;
    endfunction

    function automatic block_t mix_columns(block_t s);
        block_t r;
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, c*4);
            a1 = get_byte(s, c*4 + 1);
            a2 = get_byte(s, c*4 + 2);
            a3 = get_byte(s, c*4 + 3);
            r[127 - 32*c -: 32] = {
                xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
        end
        return r;
    endfunction

endpackage

// File: hdl/aes128_round.sv
`timescale 1ns / 1ps
// One cipher round plus its key-schedule step, registered; advances when enabled.
module aes128_round #(
    parameter logic [7:0] RoundConst = 8'h01,
    parameter bit          LastRound  = 1'b0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  valid_in,
    input  aes128_pkg::block_t    state_in,
    input  aes128_pkg::block_t    key_in,
    output logic                  valid_out,
    output aes128_pkg::block_t    state_out,
    output aes128_pkg::block_t    key_out
);

    aes128_pkg::block_t key_next;
    aes128_pkg::block_t state_next;
    aes128_pkg::block_t shifted;
    aes128_pkg::block_t state_reg;
    aes128_pkg::block_t key_reg;
    logic               valid_reg;

    always_comb
    begin
        key_next = aes128_pkg::next_round_key(key_in, RoundConst);
        shifted  = aes128_pkg::sub_shift(state_in);
        if (LastRound)
            state_next = shifted ^ key_next;
        else
            state_next = aes128_pkg::mix_columns(shifted) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;

endmodule

// File: hdl/aes128_block_encrypt.sv
`timescale 1ns / 1ps
// Pipeline: an initial AddRoundKey stage plus one registered stage per round.
// Throughput: one block per cycle; the whole pipe holds on out stall.
// Reset: asynchronous active-low, clears valid bits and key registers to zero.
module aes128_block_encrypt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  aes128_pkg::in_beat_t              in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output aes128_pkg::out_beat_t             out_data,
    input  logic                              cfg_we,
    input  logic [aes128_pkg::KeyIdxW-1:0]    cfg_index,
    input  logic [63:0]                       cfg_data
);

    logic [63:0]        key_high_reg;
    logic [63:0]        key_low_reg;
    logic               advance;
    logic               v0_reg;
    aes128_pkg::block_t s0_reg;
    aes128_pkg::block_t k0_reg;

    logic               vld [0:aes128_pkg::NumRounds];
    aes128_pkg::block_t st  [0:aes128_pkg::NumRounds];
    aes128_pkg::block_t rk  [0:aes128_pkg::NumRounds];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aes128_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes128_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stall only when the output beat is held
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (advance)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            s0_reg <= {in_data.plain_high, in_data.plain_low} ^ {key_high_reg, key_low_reg};
            k0_reg <= {key_high_reg, key_low_reg};
        end
    end

    assign vld[0] = v0_reg;
    assign st[0]  = s0_reg;
    assign rk[0]  = k0_reg;

    for (genvar r = 1; r <= aes128_pkg::NumRounds; r++)
    begin : g_round
        aes128_round #(
            .RoundConst (aes128_pkg::RCON[r]),
            .LastRound  (r == aes128_pkg::NumRounds)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (vld[r-1]),
            .state_in  (st[r-1]),
            .key_in    (rk[r-1]),
            .valid_out (vld[r]),
            .state_out (st[r]),
            .key_out   (rk[r])
        );
    end

    assign out_valid            = vld[aes128_pkg::NumRounds];
    assign out_data.cipher_high = st[aes128_pkg::NumRounds][127:64];
    assign out_data.cipher_low  = st[aes128_pkg::NumRounds][63:0];

`ifndef SYNTHESIS
    a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed under stall");
    a_in_stall_iff: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall not tied to output stall");
    a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld[0])
        else $error("accepted beat lost at first stage");
`endif

endmodule

// File: verif/aes128_checker.sv
`timescale 1ns / 1ps
module aes128_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  aes128_pkg::in_beat_t          in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  aes128_pkg::out_beat_t         out_data,
    input  logic                          cfg_we,
    input  logic [aes128_pkg::KeyIdxW-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    output int                            errors,
    output int                            pending
);

    logic [7:0] sbox_lut [256];
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    aes128_pkg::out_beat_t cipher_q[$];

    function automatic logic [7:0] gf_double(logic [7:0] v);
        return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = gf_double(a);
        end
        return acc;
    endfunction

    // S-box derived from the field inverse plus the affine map
    initial
    begin
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            inv = '0;
            for (int y = 1; y < 256; y++)
                if (gf_mul(8'(x), 8'(y)) == 8'h01)
                    inv = 8'(y);
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_lut[x] = s;
        end
    end

    function automatic logic [127:0] aes_encrypt(logic [127:0] k, logic [127:0] p);
        logic [31:0] w [44];
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [31:0] t;
        logic [7:0] rc;
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [127:0] res;
        for (int i = 0; i < 4; i++)
            w[i] = k[127 - 32*i -: 32];
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {sbox_lut[t[31:24]], sbox_lut[t[23:16]], sbox_lut[t[15:8]],
                     sbox_lut[t[7:0]]} ^ {rc, 24'h0};
                rc = gf_double(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int n = 0; n < 16; n++)
            st[n] = p[127 - 8*n -: 8];
        for (int rnd = 0; rnd <= aes128_pkg::NumRounds; rnd++)
        begin
            if (rnd > 0)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[c*4 + r] = sbox_lut[st[((c + r) % 4)*4 + r]];
                st = tmp;
            end
            if (rnd > 0 && rnd < aes128_pkg::NumRounds)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[c*4];
                    a1 = st[c*4 + 1];
                    a2 = st[c*4 + 2];
                    a3 = st[c*4 + 3];
                    st[c*4]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                    st[c*4 + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                    st[c*4 + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                    st[c*4 + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[c*4 + r] ^= w[rnd*4 + c][31 - 8*r -: 8];
        end
        for (int n = 0; n < 16; n++)
            res[127 - 8*n -: 8] = st[n];
        return res;
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
        key_hi = '0;
        key_lo = '0;
    end

    // inputs change only at posedge, so the negedge sees what the next edge accepts
    always @(negedge clk)
    begin
        aes128_pkg::out_beat_t exp_beat;
        if (!rst_n)
        begin
            key_hi = '0;
            key_lo = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (cipher_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected beat %h", out_data);
                end
                else
                begin
                    exp_beat = cipher_q.pop_front();
                    if (out_data.cipher_high !== exp_beat.cipher_high
                        || out_data.cipher_low !== exp_beat.cipher_low)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: cipher exp %h_%h got %h_%h",
                                     exp_beat.cipher_high, exp_beat.cipher_low,
                                     out_data.cipher_high, out_data.cipher_low);
                    end
                end
            end
            if (in_valid && !in_stall)
                cipher_q.push_back(aes128_pkg::out_beat_t'(
                    aes_encrypt({key_hi, key_lo}, in_data)));
            if (cfg_we)
            begin
                if (cfg_index == aes128_pkg::REG_KEY_HIGH)
                    key_hi = cfg_data;
                else if (cfg_index == aes128_pkg::REG_KEY_LOW)
                    key_lo = cfg_data;
            end
        end
        pending = cipher_q.size();
    end

endmodule

// File: verif/aes128_block_encrypt_tb.sv
`timescale 1ns / 1ps
module aes128_block_encrypt_tb;

    localparam int TimeoutCycles = 200000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    aes128_pkg::in_beat_t in_data;
    logic out_valid;
    logic out_stall;
    aes128_pkg::out_beat_t out_data;
    logic cfg_we;
    logic [aes128_pkg::KeyIdxW-1:0] cfg_index;
    logic [63:0] cfg_data;
    int errors;
    int pending;
    int cycles;
    int hold_left;
    int hold_req;
    bit quiet;
    int n_blocks;

    aes128_block_encrypt i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    aes128_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > TimeoutCycles)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(0, 99) < 9);
        end
    end

    task automatic send_block(logic [63:0] hi, logic [63:0] lo);
        bit stalled;
        while (!quiet && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{plain_high: hi, plain_low: lo};
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        n_blocks++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || hold_left > 0 || hold_req > 0)
            @(posedge clk);
        repeat (14) @(posedge clk);
    endtask

    task automatic write_key(logic [63:0] hi, logic [63:0] lo);
        cfg_we <= 1'b1;
        cfg_index <= aes128_pkg::REG_KEY_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        cfg_index <= aes128_pkg::REG_KEY_LOW;
        cfg_data <= lo;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_set();
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block({8{8'h55}}, {8{8'haa}});
        send_block(64'h8000000000000000, 64'h0000000000000001);
    endtask

    task automatic random_run(int count);
        for (int i = 0; i < count; i++)
            send_block({$urandom, $urandom}, {$urandom, $urandom});
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = aes128_pkg::REG_KEY_HIGH;
        cfg_data = '0;
        cycles = 0;
        hold_left = 0;
        hold_req = 0;
        quiet = 1'b0;
        n_blocks = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key of all zeros
        directed_set();
        drain();
        write_key('1, '1);
        directed_set();
        drain();
        write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        directed_set();
        drain();
        write_key('1, '0);
        directed_set();
        drain();

        for (int k = 0; k < 5; k++)
        begin
            write_key({$urandom, $urandom}, {$urandom, $urandom});
            quiet = (k == 2);
            if (k == 1)
                hold_req = 300;
            random_run(250);
            drain();
        end
        quiet = 1'b0;

        $display("Encrypted %0d blocks under 9 keys (zero, all-ones, FIPS-197 and random),",
                 n_blocks);
        $display("with random stalls on both sides, a long output hold and full drains.");
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
